// ----- src/hq_pkg.sv -----
// ----------------------------------------------------------------------------
// hq_pkg
// Shared types and codes for the four-ary max heap queue.
// ----------------------------------------------------------------------------
package hq_pkg;

    localparam int ARITY   = 4;
    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 16;
    localparam int ENTRY_W = PRIO_W + TAG_W;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 11;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Priority reported by a remove on an empty queue
    localparam logic signed [PRIO_W-1:0] EMPTY_PRIO = -16'sd1;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } entry_t;

    // One memory row holds the ARITY children of one node
    typedef entry_t [ARITY-1:0] row_t;

    typedef struct packed {
        logic                     kind;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]         payload;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [PRIO_W-1:0] out_priority;
        logic [TAG_W-1:0]         out_payload;
        logic [OCC_W-1:0]         occupancy;
    } rsp_t;

    typedef struct packed {
        logic                     rd_en;
        logic                     wr_en;
        logic [1:0]               wr_lane;
    } mem_ctl_t;

endpackage

// ----- src/hq_req_if.sv -----
// ----------------------------------------------------------------------------
// hq_req_if
// Request channel: valid/ready handshake carrying one queue operation.
// ----------------------------------------------------------------------------
interface hq_req_if;

    logic        valid;
    logic        ready;
    hq_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- src/hq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hq_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface hq_rsp_if;

    logic        valid;
    logic        ready;
    hq_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- src/hq_store.sv -----
// ----------------------------------------------------------------------------
// hq_store
// Heap storage for entries 1 and up, one row per parent node holding its
// four children. Lane-wide write, row-wide read, registered read data.
// ----------------------------------------------------------------------------
module hq_store #(
    parameter int ROWS  = 256,
    parameter int ROW_W = 8
) (
    input  logic              clk,
    input  hq_pkg::mem_ctl_t  ctl,
    input  logic [ROW_W-1:0]  rd_row,
    input  logic [ROW_W-1:0]  wr_row,
    input  hq_pkg::entry_t    wr_data,
    output hq_pkg::row_t      rd_data
);

    hq_pkg::row_t mem [ROWS];
    hq_pkg::row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_row][ctl.wr_lane] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/hq_pick.sv -----
// ----------------------------------------------------------------------------
// hq_pick
// Child selection: greatest priority among lane 0 and the valid upper lanes
// of a row, the lowest lane winning a tie.
// ----------------------------------------------------------------------------
module hq_pick (
    input  hq_pkg::row_t             row,
    input  logic [hq_pkg::ARITY-1:0] lane_valid,
    output logic [1:0]               best_lane,
    output hq_pkg::entry_t           best_entry
);

    always_comb
    begin
        best_lane  = 2'd0;
        best_entry = row[0];
        for (int k = 1; k < hq_pkg::ARITY; k++)
        begin
            // strictly greater keeps the lower lane on a tie
            if (lane_valid[k] && (row[k].prio > best_entry.prio))
            begin
                best_lane  = 2'(k);
                best_entry = row[k];
            end
        end
    end

endmodule

// ----- src/four_ary_max_heap_queue_unit.sv -----
// ----------------------------------------------------------------------------
// four_ary_max_heap_queue_unit
// Max priority queue kept as a four-ary heap. The root sits in a register,
// the other entries in a row memory where row n holds the children of node n.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | kind, priority_req, payload
//   rsp     | out | valid/ready   | status, out_priority, out_payload, occupancy
//
// Operation: one at a time. Insert climbs one level per read and compare
// step, stopping below a parent that is not smaller or on reaching the root.
// Remove reads the last entry, moves it to the root position and descends
// one level per read and compare step, stopping on a node with no children
// or when no child is greater. A full insert, an empty remove or removing
// the only entry goes straight to the finish state. The unit returns to idle
// before the next request is taken. Each level costs one read of the single
// memory read port and one compare step.
// Reset: clears the entry count, the state and the output valid flag; no memory clearing pass.
// Stalls: req is taken in the idle state even while a result waits in the
// output register; a finished result holds until the output register frees.
// ----------------------------------------------------------------------------
module four_ary_max_heap_queue_unit #(
    parameter int CAPACITY = 1024
) (
    input logic      clk,
    input logic      rst_n,
    hq_req_if.sink   req,
    hq_rsp_if.source rsp
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ROWS    = (CAPACITY - 2) / hq_pkg::ARITY + 1;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CHILD_W = IDX_W + 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_LOAD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         cur_reg;
    hq_pkg::entry_t           moving_reg;
    hq_pkg::entry_t           root_reg;
    logic [hq_pkg::STAT_W-1:0] res_status_reg;
    hq_pkg::entry_t           res_entry_reg;
    hq_pkg::rsp_t             rsp_reg;
    logic                     out_valid_reg;

    hq_pkg::mem_ctl_t         mem_ctl;
    logic [ROW_W-1:0]         rd_row;
    logic [ROW_W-1:0]         cur_row;
    hq_pkg::entry_t           wr_data;
    hq_pkg::row_t             row_q;

    logic [IDX_W-1:0]         cur_m1;
    logic [IDX_W-1:0]         parent_idx;
    logic [IDX_W-1:0]         parent_m1;
    logic [CNT_W-1:0]         last_m1;
    logic [CHILD_W-1:0]       child_base;
    logic [CHILD_W-1:0]       count_ext;
    logic [hq_pkg::ARITY-1:0] lane_valid;
    logic [1:0]               best_lane;
    hq_pkg::entry_t           best_entry;
    logic [IDX_W-1:0]         best_idx;
    hq_pkg::entry_t           par_entry;
    logic                     up_move;
    logic                     dn_move;
    logic [CNT_W+hq_pkg::OCC_W-1:0] occ_full;
    logic                     rsp_load;

    assign cur_m1     = cur_reg - IDX_W'(1);
    assign cur_row    = ROW_W'(cur_m1 >> 2);
    assign parent_idx = cur_m1 >> 2;
    assign parent_m1  = parent_idx - IDX_W'(1);
    assign last_m1    = count_reg - CNT_W'(1);
    assign child_base = (CHILD_W'(cur_reg) << 2) + CHILD_W'(1);
    assign count_ext  = CHILD_W'(count_reg);
    assign best_idx   = IDX_W'(child_base + CHILD_W'(best_lane));
    assign occ_full   = {{hq_pkg::OCC_W{1'b0}}, count_reg};

    // load the output register when a result is done and the register frees
    assign rsp_load = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        for (int k = 0; k < hq_pkg::ARITY; k++)
        begin
            lane_valid[k] = (child_base + CHILD_W'(k)) < count_ext;
        end
    end

    // parent of the root level is the root register, not the memory
    assign par_entry = (parent_idx == '0) ? root_reg : row_q[parent_m1[1:0]];
    assign up_move   = moving_reg.prio > par_entry.prio;
    assign dn_move   = best_entry.prio > moving_reg.prio;

    hq_pick u_pick (
        .row        (row_q),
        .lane_valid (lane_valid),
        .best_lane  (best_lane),
        .best_entry (best_entry)
    );

    hq_store #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_row  (rd_row),
        .wr_row  (cur_row),
        .wr_data (wr_data),
        .rd_data (row_q)
    );

    always_comb
    begin
        mem_ctl.rd_en   = 1'b0;
        mem_ctl.wr_en   = 1'b0;
        mem_ctl.wr_lane = cur_m1[1:0];
        rd_row          = ROW_W'(cur_reg);
        wr_data         = moving_reg;
        unique case (state_reg)
            ST_UP_RD:
            begin
                mem_ctl.rd_en = (cur_reg != '0) && (parent_idx != '0);
                rd_row        = ROW_W'(parent_m1 >> 2);
            end
            ST_UP_CMP:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_data       = up_move ? par_entry : moving_reg;
            end
            ST_DN_LAST:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_row        = ROW_W'(last_m1 >> 2);
            end
            ST_DN_RD:
            begin
                mem_ctl.rd_en = lane_valid[0];
                mem_ctl.wr_en = !lane_valid[0] && (cur_reg != '0);
            end
            ST_DN_CMP:
            begin
                mem_ctl.wr_en = (cur_reg != '0);
                wr_data       = dn_move ? best_entry : moving_reg;
            end
            ST_IDLE, ST_DN_LOAD, ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        moving_reg <= {req.data.priority_req, req.data.payload};
                        if (req.data.kind == hq_pkg::KIND_INSERT)
                        begin
                            res_entry_reg <= '0;
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_reg <= hq_pkg::STAT_FULL;
                                state_reg      <= ST_FINISH;
                            end
                            else
                            begin
                                res_status_reg <= hq_pkg::STAT_OK;
                                cur_reg        <= IDX_W'(count_reg);
                                count_reg      <= count_reg + CNT_W'(1);
                                state_reg      <= ST_UP_RD;
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_reg     <= hq_pkg::STAT_EMPTY;
                                res_entry_reg.prio <= hq_pkg::EMPTY_PRIO;
                                res_entry_reg.tag  <= '0;
                                state_reg          <= ST_FINISH;
                            end
                            else
                            begin
                                res_status_reg <= hq_pkg::STAT_OK;
                                res_entry_reg  <= root_reg;
                                count_reg      <= count_reg - CNT_W'(1);
                                state_reg      <= (count_reg == CNT_W'(1)) ? ST_FINISH
                                                                           : ST_DN_LAST;
                            end
                        end
                    end
                end
                ST_UP_RD:
                begin
                    if (cur_reg == '0)
                    begin
                        root_reg  <= moving_reg;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_UP_CMP;
                    end
                end
                ST_UP_CMP:
                begin
                    if (up_move)
                    begin
                        cur_reg   <= parent_idx;
                        state_reg <= ST_UP_RD;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_DN_LAST:
                begin
                    state_reg <= ST_DN_LOAD;
                end
                ST_DN_LOAD:
                begin
                    moving_reg <= row_q[last_m1[1:0]];
                    cur_reg    <= '0;
                    state_reg  <= ST_DN_RD;
                end
                ST_DN_RD:
                begin
                    if (lane_valid[0])
                    begin
                        state_reg <= ST_DN_CMP;
                    end
                    else
                    begin
                        if (cur_reg == '0)
                        begin
                            root_reg <= moving_reg;
                        end
                        state_reg <= ST_FINISH;
                    end
                end
                ST_DN_CMP:
                begin
                    if (dn_move)
                    begin
                        if (cur_reg == '0)
                        begin
                            root_reg <= best_entry;
                        end
                        cur_reg   <= best_idx;
                        state_reg <= ST_DN_RD;
                    end
                    else
                    begin
                        if (cur_reg == '0)
                        begin
                            root_reg <= moving_reg;
                        end
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // hold until the output register frees
                    if (rsp_load)
                    begin
                        rsp_reg.status       <= res_status_reg;
                        rsp_reg.out_priority <= res_entry_reg.prio;
                        rsp_reg.out_payload  <= res_entry_reg.tag;
                        rsp_reg.occupancy    <= occ_full[hq_pkg::OCC_W-1:0];
                        state_reg            <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted transaction did not start work");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.data.kind == hq_pkg::KIND_INSERT)
         && (count_reg != CNT_W'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not bump entry count");

endmodule
